// ===== src/vsc_pkg.sv =====
// vsc_pkg: shared types and constants of the version string comparator
// holds the phase encoding, the comparison state record and the order codes
// no dependencies
package vsc_pkg;

  localparam logic [7:0] CHAR_NUL  = 8'h00;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  localparam logic signed [1:0] ORD_LT = -2'sd1;
  localparam logic signed [1:0] ORD_EQ = 2'sd0;
  localparam logic signed [1:0] ORD_GT = 2'sd1;

  typedef enum logic [2:0] {
    PH_PREFIX = 3'b001,
    PH_RUNS   = 3'b010,
    PH_DONE   = 3'b100
  } phase_t;

  typedef struct packed {
    phase_t             phase;
    logic               all_zero;
    logic signed [1:0]  tie;
  } state_t;

  typedef struct packed {
    logic               emit;
    logic signed [1:0]  order;
  } decide_t;

  localparam state_t STATE_CLEAR = '{phase: PH_PREFIX, all_zero: 1'b1, tie: ORD_EQ};

endpackage

// ===== src/version_string_compare.sv =====
// version_string_compare: top level, one aligned byte pair of two version strings per transfer,
// one order result per comparison. A result is registered after the deciding pair passes one
// input register, the decision logic, then the result register. The comparison state update
// is the loop that fixes one pair per cycle unless the output stalls. A pair marked first
// clears the state before it is evaluated; pairs after the decision and before the next first
// pair give nothing. Order is -1, 0 or 1, bytes compare unsigned.
// depends on vsc_pkg and vsc_decide
module version_string_compare (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_first,
  input  logic [7:0]        in_a_char,
  input  logic [7:0]        in_b_char,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [1:0] out_order
);

  logic              in_valid_r;
  logic              in_first_r;
  logic [7:0]        a_char_r;
  logic [7:0]        b_char_r;
  vsc_pkg::state_t   state_r;
  vsc_pkg::state_t   state_nxt;
  vsc_pkg::decide_t  result;
  logic              out_valid_r;
  logic signed [1:0] out_order_r;
  logic              advance;

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !in_valid_r || advance;

  vsc_decide u_decide (
    .first     (in_first_r),
    .a_char    (a_char_r),
    .b_char    (b_char_r),
    .state_cur (state_r),
    .state_nxt (state_nxt),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= vsc_pkg::STATE_CLEAR;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r && result.emit;
        if (in_valid_r) begin
          state_r <= state_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_first_r <= in_first;
      a_char_r   <= in_a_char;
      b_char_r   <= in_b_char;
    end
    if (advance && in_valid_r && result.emit) begin
      out_order_r <= result.order;
    end
  end

  assign out_valid = out_valid_r;
  assign out_order = out_order_r;

endmodule

// ===== src/vsc_decide.sv =====
// vsc_decide: per byte pair decision logic of the version string comparator
// computes the next comparison state and an optional order result
// depends on vsc_pkg
module vsc_decide (
  input  logic              first,
  input  logic [7:0]        a_char,
  input  logic [7:0]        b_char,
  input  vsc_pkg::state_t   state_cur,
  output vsc_pkg::state_t   state_nxt,
  output vsc_pkg::decide_t  result
);

  vsc_pkg::state_t cur;
  logic            da;
  logic            db;
  logic signed [1:0] byte_ord;

  assign cur      = first ? vsc_pkg::STATE_CLEAR : state_cur;
  assign da       = (a_char >= vsc_pkg::CHAR_ZERO) && (a_char <= vsc_pkg::CHAR_NINE);
  assign db       = (b_char >= vsc_pkg::CHAR_ZERO) && (b_char <= vsc_pkg::CHAR_NINE);
  assign byte_ord = (a_char < b_char) ? vsc_pkg::ORD_LT : vsc_pkg::ORD_GT;

  always_comb begin
    state_nxt    = cur;
    result.emit  = 1'b0;
    result.order = vsc_pkg::ORD_EQ;
    case (cur.phase)
      vsc_pkg::PH_PREFIX: begin
        if (a_char == b_char) begin
          if (a_char == vsc_pkg::CHAR_NUL) begin
            result.emit = 1'b1;
          end else if (da) begin
            state_nxt.all_zero = cur.all_zero & (a_char == vsc_pkg::CHAR_ZERO);
          end else begin
            state_nxt.all_zero = 1'b1;
          end
        end else if (!da || !db) begin
          result.emit  = 1'b1;
          result.order = byte_ord;
        end else if (cur.all_zero && (a_char == vsc_pkg::CHAR_ZERO)) begin
          result.emit  = 1'b1;
          result.order = vsc_pkg::ORD_LT;
        end else if (cur.all_zero && (b_char == vsc_pkg::CHAR_ZERO)) begin
          result.emit  = 1'b1;
          result.order = vsc_pkg::ORD_GT;
        end else begin
          state_nxt.tie   = byte_ord;
          state_nxt.phase = vsc_pkg::PH_RUNS;
        end
      end
      vsc_pkg::PH_RUNS: begin
        if (da && !db) begin
          result.emit  = 1'b1;
          result.order = vsc_pkg::ORD_GT;
        end else if (!da && db) begin
          result.emit  = 1'b1;
          result.order = vsc_pkg::ORD_LT;
        end else if (!da && !db) begin
          result.emit  = 1'b1;
          result.order = cur.tie;
        end
      end
      default: begin
      end
    endcase
    if (result.emit) begin
      state_nxt.phase = vsc_pkg::PH_DONE;
    end
  end

endmodule

// ===== src/vsc_checker.sv =====
// vsc_checker: port level assertions for version_string_compare
// bound to the top level, sees its ports only
// depends on version_string_compare
module vsc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_first,
  input logic [7:0]        in_a_char,
  input logic [7:0]        in_b_char,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [1:0] out_order
);

  // stalled result transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_order))
    else $error("result changed while stalled");

  a_order_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_order != 2'b10)
    else $error("illegal order code");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input blocked while output drains");

  // a fresh comparison of two empty strings is equal once the result register may advance
  a_empty_equal: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_first && in_a_char == 8'h00 && in_b_char == 8'h00)
    ##1 (!out_valid || out_ready) |=> out_valid && out_order == 2'sd0)
    else $error("empty strings not reported equal");

  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind version_string_compare vsc_checker u_vsc_checker (.*);
